[sv/fpa_pkg.sv]
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_FINT = 4'd8,
    OP_TINT = 4'd9
  } op_t;

  // Divider operand widths: magnitudes of numerator and denominator.
  localparam int NUM_W = 64;
  localparam int DEN_W = 32;

  // State handed from one divider cell to the next.
  typedef struct packed {
    logic              vld;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  quo;
    logic [DEN_W:0]    rem;
    logic              neg;
    logic              dz;
    logic              fast_ov;
    logic [3:0]        op;
    logic [31:0]       fast;
    logic [2:0]        cmp;
  } cell_t;

endpackage

[sv/fixed_point_alu.sv]
// A word passes stage 0, row[0], the divider cells and the output register.
// Throughput: one word per cycle; the row of 32 divider cells, two quotient
// bits each, moves in lockstep and stalls only when the output is not taken.
// Every opcode travels the same row so results leave in order.
// Reset clears all valid bits; payload registers are not reset.
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result,
  output logic               less,
  output logic               equal,
  output logic               greater,
  output logic               overflow,
  output logic               div_zero
);

  localparam int NCELL = 32;
  localparam int STEPS = NUM_W / NCELL;

  logic  en;
  cell_t row [NCELL+1];

  // Stage 0 registers; the whole row advances together.
  logic              s0_vld;
  logic [3:0]        s0_op;
  logic signed [31:0] s0_a, s0_b;
  logic signed [63:0] s0_prod;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_valid;
    end
    if (en) begin
      s0_op   <= op;
      s0_a    <= a;
      s0_b    <= b;
      s0_prod <= 64'(a) * 64'(b);
    end
  end

  // Stage 1: all non-divide results plus divider setup.
  cell_t st1;
  always_comb begin
    logic signed [33:0] sum;
    logic signed [63:0] rnd, shf, sh_a;
    logic [63:0]        mag, nmag;
    logic signed [63:0] half;
    logic               ov;
    logic signed [31:0] r;
    half = 64'sd1 <<< (FRAC_BITS - 1);
    ov   = 1'b0;
    r    = '0;
    sum  = '0;
    rnd  = '0;
    shf  = '0;
    nmag = '0;
    sh_a = 64'(s0_a) <<< FRAC_BITS;
    mag  = s0_prod[63] ? 64'(-s0_prod) : 64'(s0_prod);
    case (s0_op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        case (s0_op)
          OP_ADD:  sum = 34'(s0_a) + 34'(s0_b);
          OP_SUB:  sum = 34'(s0_a) - 34'(s0_b);
          OP_INC:  sum = 34'(s0_a) + 34'sd1;
          default: sum = 34'(s0_a) - 34'sd1;
        endcase
        if (sum > 34'sh7FFFFFFF) begin
          ov = 1'b1; r = 32'sh7FFFFFFF;
        end else if (sum < -34'sh80000000) begin
          ov = 1'b1; r = 32'sh80000000;
        end else begin
          r = sum[31:0];
        end
      end
      OP_MUL, OP_FINT: begin
        if (s0_op == OP_MUL) begin
          nmag = (mag + 64'(half)) >> FRAC_BITS;
          rnd  = s0_prod[63] ? -$signed(nmag) : $signed(nmag);
        end else begin
          rnd = sh_a;
        end
        if (rnd > 64'sh7FFFFFFF) begin
          ov = 1'b1; r = 32'sh7FFFFFFF;
        end else if (rnd < -64'sh80000000) begin
          ov = 1'b1; r = 32'sh80000000;
        end else begin
          r = rnd[31:0];
        end
      end
      OP_MIN:  r = (s0_a < s0_b) ? s0_a : s0_b;
      OP_MAX:  r = (s0_a > s0_b) ? s0_a : s0_b;
      OP_TINT: begin
        shf = 64'(s0_a) >>> FRAC_BITS;
        r   = shf[31:0];
      end
      default: r = '0;
    endcase
    st1.vld     = s0_vld;
    st1.num     = sh_a[63] ? 64'(-sh_a) : 64'(sh_a);
    st1.den     = s0_b[31] ? 32'(-s0_b) : 32'(s0_b);
    st1.quo     = '0;
    st1.rem     = '0;
    st1.neg     = s0_a[31] ^ s0_b[31];
    st1.dz      = (s0_op == OP_DIV) && (s0_b == '0);
    st1.fast_ov = ov;
    st1.op      = s0_op;
    st1.fast    = r;
    st1.cmp     = {s0_a < s0_b, s0_a == s0_b, s0_a > s0_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0].vld <= 1'b0;
    end else if (en) begin
      row[0].vld <= st1.vld;
    end
    if (en) begin
      row[0].num     <= st1.num;
      row[0].den     <= st1.den;
      row[0].quo     <= st1.quo;
      row[0].rem     <= st1.rem;
      row[0].neg     <= st1.neg;
      row[0].dz      <= st1.dz;
      row[0].fast_ov <= st1.fast_ov;
      row[0].op      <= st1.op;
      row[0].fast    <= st1.fast;
      row[0].cmp     <= st1.cmp;
    end
  end

  // Row of divider cells.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    fpa_cell #(.STEPS(STEPS)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (row[g]),
      .dout(row[g+1])
    );
  end

  // Output: other ops pass the stage 1 result; a divide rounds the quotient half up on the remainder, then saturates.
  cell_t tl;
  logic [31:0] fin;
  logic        fin_ov;
  always_comb begin
    logic [64:0] q;
    tl     = row[NCELL];
    fin    = tl.fast;
    fin_ov = tl.fast_ov;
    q      = 65'(tl.quo) + 65'(({tl.rem, 1'b0} >= 34'(tl.den)) ? 1'b1 : 1'b0);
    if (tl.op == OP_DIV) begin
      fin_ov = 1'b0;
      if (tl.dz) begin
        fin = tl.neg ^ tl.den[31] ? 32'h80000000 : 32'h7FFFFFFF;
      end else if (!tl.neg) begin
        if (q > 65'h7FFFFFFF) begin
          fin = 32'h7FFFFFFF; fin_ov = 1'b1;
        end else begin
          fin = q[31:0];
        end
      end else begin
        if (q > 65'h80000000) begin
          fin = 32'h80000000; fin_ov = 1'b1;
        end else begin
          fin = 32'(-q[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tl.vld;
    end
    if (en) begin
      result   <= fin;
      less     <= tl.cmp[2];
      equal    <= tl.cmp[1];
      greater  <= tl.cmp[0];
      overflow <= fin_ov;
      div_zero <= tl.dz;
    end
  end

endmodule

[sv/fpa_cell.sv]
module fpa_cell
  import fpa_pkg::*;
#(
  parameter int STEPS = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t din,
  output cell_t dout
);

  cell_t nxt;

  // STEPS restoring division steps, one quotient bit each.
  always_comb begin
    logic [DEN_W:0] trial;
    nxt = din;
    for (int i = 0; i < STEPS; i++) begin
      nxt.rem = {nxt.rem[DEN_W-1:0], nxt.num[NUM_W-1]};
      nxt.num = {nxt.num[NUM_W-2:0], 1'b0};
      trial   = nxt.rem - {1'b0, nxt.den};
      if (!trial[DEN_W]) begin
        nxt.rem = trial;
        nxt.quo = {nxt.quo[NUM_W-2:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.num     <= nxt.num;
      dout.den     <= nxt.den;
      dout.quo     <= nxt.quo;
      dout.rem     <= nxt.rem;
      dout.neg     <= nxt.neg;
      dout.dz      <= nxt.dz;
      dout.fast_ov <= nxt.fast_ov;
      dout.op      <= nxt.op;
      dout.fast    <= nxt.fast;
      dout.cmp     <= nxt.cmp;
    end
  end

endmodule

[sv/fpa_checker.sv]
module fpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result,
  input logic        less,
  input logic        equal,
  input logic        greater,
  input logic        overflow,
  input logic        div_zero
);

  // Exactly one comparison flag holds on every word.
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({less, equal, greater}))
    else $error("comparison flags not one-hot");

  // Divide by zero never reports overflow.
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> !overflow)
    else $error("overflow with divide by zero");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("result dropped under stall");

  // Input is taken whenever the output is free.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

[dv/fixed_point_alu_checker.sv]
module fixed_point_alu_checker
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] result,
  input  logic               less,
  input  logic               equal,
  input  logic               greater,
  input  logic               overflow,
  input  logic               div_zero,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               ovf;
    logic               dz;
  } alu_word_t;

  alu_word_t expected_words[$];

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [127:0] v,
                                               inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Compute the expected word for one operation.
  function automatic alu_word_t alu_predict(input logic [3:0] opc,
                                            input logic signed [31:0] x,
                                            input logic signed [31:0] y);
    alu_word_t w;
    logic signed [127:0] p, num, q;
    logic [127:0] mag_p, mag_d;
    logic ovf;
    ovf = 1'b0;
    w = '0;
    case (opc)
      OP_ADD: w.value = sat32(128'(x) + 128'(y), ovf);
      OP_SUB: w.value = sat32(128'(x) - 128'(y), ovf);
      OP_MUL: begin
        p = 128'(x) * 128'(y);
        mag_p = p < 0 ? -p : p;
        q = (mag_p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        w.value = sat32(p < 0 ? -q : q, ovf);
      end
      OP_DIV: begin
        if (y == 0) begin
          w.dz = 1'b1;
          w.value = x >= 0 ? 32'sh7fffffff : 32'sh80000000;
        end else begin
          num = 128'(x) <<< FRAC_BITS;
          mag_p = num < 0 ? -num : num;
          mag_d = y < 0 ? -128'(y) : 128'(y);
          q = (2 * mag_p + mag_d) / (2 * mag_d);
          w.value = sat32(((num < 0) != (y < 0)) ? -q : q, ovf);
        end
      end
      OP_MIN: w.value = x < y ? x : y;
      OP_MAX: w.value = x > y ? x : y;
      OP_INC: w.value = sat32(128'(x) + 1, ovf);
      OP_DEC: w.value = sat32(128'(x) - 1, ovf);
      OP_FINT: w.value = sat32(128'(x) <<< FRAC_BITS, ovf);
      OP_TINT: w.value = x >>> FRAC_BITS;
      default: w.value = '0;
    endcase
    w.ovf = ovf;
    w.lt = x < y;
    w.eq = x == y;
    w.gt = x > y;
    return w;
  endfunction

  assign pending = expected_words.size();

  // Predict on each accepted input word, compare on each accepted output word.
  always @(posedge clk) begin
    alu_word_t exp_w, got_w;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_words.push_back(alu_predict(op, a, b));
      end
      if (out_valid && out_ready) begin
        got_w = '{result, less, equal, greater, overflow, div_zero};
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) begin
            $display("unexpected output word %h", got_w);
          end
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w !== exp_w) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("mismatch: expected result=%h lt=%b eq=%b gt=%b ov=%b dz=%b",
                       exp_w.value, exp_w.lt, exp_w.eq, exp_w.gt, exp_w.ovf, exp_w.dz);
              $display("          actual   result=%h lt=%b eq=%b gt=%b ov=%b dz=%b",
                       result, less, equal, greater, overflow, div_zero);
            end
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

[dv/fixed_point_alu_test.sv]
module fixed_point_alu_test;
  import fpa_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         op;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] result;
  logic               less;
  logic               equal;
  logic               greater;
  logic               overflow;
  logic               div_zero;
  int                 fail_count;
  int                 pending;
  logic               calm;
  logic               hold_off;

  fixed_point_alu u_dut (.*);

  fixed_point_alu_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // Random operand with bias toward edge values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3: return 32'(int'($urandom_range(0, 4095)) - 2048);
      4: return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Present one word and wait for it to be taken; valid drops only while idling.
  task automatic send_word(input logic [3:0] opc, input logic [31:0] x,
                           input logic [31:0] y);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= opc;
    a <= x;
    b <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls, with a calm stretch and one long hold-off.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h100};
    rst = 1'b1;
    in_valid = 1'b0;
    op = '0;
    a = '0;
    b = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every opcode, unknown ones included, on edge operands.
    for (int k = 0; k < 16; k++) begin
      send_word(4'(k), edges[k % 6], edges[(k + 1) % 6]);
    end
    send_word(OP_DIV, 32'h00000500, 32'h0);
    send_word(OP_DIV, 32'hfffff000, 32'h0);
    send_word(OP_MUL, 32'h80000000, 32'h80000000);
    send_word(OP_DIV, 32'h00000003, 32'h00000200);
    send_word(OP_DIV, 32'hfffffffd, 32'h00000200);
    send_word(OP_MUL, 32'h00000080, 32'hffffffff);
    send_word(OP_TINT, 32'hffffff01, 32'h0);

    // Long hold-off on the receiver while words keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 60; k++) begin
        send_word(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      end
    join

    // Random words, with a calm middle stretch.
    for (int k = 0; k < 1600; k++) begin
      calm = (k >= 600 && k < 800);
      send_word(4'($urandom_range(0, 15)), pick_operand(),
                ($urandom_range(0, 3) == 0) ? pick_operand() : pick_operand());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
sv/fpa_pkg.sv
sv/fpa_cell.sv
sv/fixed_point_alu.sv
sv/fpa_checker.sv
dv/fixed_point_alu_checker.sv
dv/fixed_point_alu_test.sv
